/* src/pwmsdw_pkg.sv */
// ----------------------------------------------------------------------------
// PWM shadow store package
// Transaction types, register indexes, sequencer states and fixed constants
// shared by the PWM shadow store with dirty write-back.
// ----------------------------------------------------------------------------
package pwmsdw_pkg;

    typedef struct packed {
        logic        op;
        logic [3:0]  channel;
        logic [15:0] duty;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  bus_address;
        logic [6:0]  reg_address;
        logic [12:0] on_count;
        logic [12:0] off_count;
        logic        run_first;
        logic        run_last;
        logic        last;
    } out_item_t;

    typedef enum logic {
        OP_SET    = 1'b0,
        OP_UPDATE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CFG_ADDRESS_BASE = 2'd0,
        CFG_DEVICE_INDEX = 2'd1,
        CFG_FULL_ON_CODE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_FETCH = 2'd2
    } state_t;

    localparam int unsigned CFG_DATA_W = 13;

    localparam logic [7:0]  ADDRESS_BASE_RST = 8'd128;
    localparam logic [1:0]  DEVICE_INDEX_RST = 2'd0;
    localparam logic [12:0] FULL_ON_CODE_RST = 13'd4096;

    localparam logic [6:0]  REG_ADDR_BASE = 7'd6;
    localparam logic [15:0] DUTY_FULL_ON  = 16'hFFFF;
    localparam logic [15:0] DUTY_FULL_OFF = 16'h0000;

endpackage

/* src/pwm_shadow_dirty_write_back.sv */
// ----------------------------------------------------------------------------
// PWM shadow store with dirty write-back
// Holds one duty value per channel with a dirty mark and, on an update,
// walks the channels in order and issues one register write per dirty one.
// ----------------------------------------------------------------------------
// Input transactions arrive on in_valid/in_ready with an in_data payload. A set
// transaction stores a duty value for one channel and marks it dirty. An update
// transaction starts a walk over the channels in order through a shifting copy
// of the dirty mask, which stops after the highest dirty channel. A clean
// channel passes through the scan state only and a dirty channel through the
// scan and fetch states, the fetch for the registered read of its stored value.
// In_ready is low during the walk.
// Each result is a register write on out_valid/out_ready, held in an output
// register; the walk waits while that register is full and the receiver
// stalls. The first result passes through the scan and fetch states and the
// output register, after one scan step for each clean channel below the
// lowest dirty one. The configuration port takes a write on any cycle with
// cfg_write high. Reset clears the dirty marks, the walk and the output valid
// flag and loads the configuration reset values; duty values stay undefined.
// ----------------------------------------------------------------------------
module pwm_shadow_dirty_write_back
    import pwmsdw_pkg::*;
#(
    parameter int unsigned CHANNELS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data
);

    localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [7:0]          address_base_reg;
    logic [1:0]          device_index_reg;
    logic [12:0]         full_on_code_reg;

    logic [15:0]         values_mem [CHANNELS];
    logic [15:0]         rd_data_reg;

    state_t              state_reg;
    state_t              state_next;
    logic [CHANNELS-1:0] dirty_reg;
    logic [CHANNELS-1:0] dirty_next;
    logic [CHANNELS-1:0] pend_reg;
    logic [CHANNELS-1:0] pend_next;
    logic [CHANNELS-1:0] pend_shifted;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic                prev_reg;
    logic                prev_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    out_item_t           out_reg;
    out_item_t           out_next;

    logic                in_accept;
    logic                set_accept;
    logic                upd_accept;
    logic                set_in_range;
    logic                slot_free;
    logic                do_load;
    logic                do_skip;
    logic                more_dirty;
    logic [12:0]         on_val;
    logic [12:0]         off_val;

    assign in_accept    = in_valid && in_ready;
    assign set_in_range = ({1'b0, in_data.channel} < 5'(CHANNELS));
    assign set_accept   = in_accept && (in_data.op == OP_SET);
    assign upd_accept   = in_accept && (in_data.op == OP_UPDATE);
    assign slot_free    = !out_valid_reg || out_ready;
    assign pend_shifted = pend_reg >> 1;
    assign more_dirty   = |pend_shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_base_reg <= ADDRESS_BASE_RST;
            device_index_reg <= DEVICE_INDEX_RST;
            full_on_code_reg <= FULL_ON_CODE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ADDRESS_BASE: address_base_reg <= cfg_data[7:0];
                CFG_DEVICE_INDEX: device_index_reg <= cfg_data[1:0];
                CFG_FULL_ON_CODE: full_on_code_reg <= cfg_data[12:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (set_accept && set_in_range)
        begin
            values_mem[in_data.channel[CW-1:0]] <= in_data.duty;
        end
        rd_data_reg <= values_mem[cnt_reg];
    end

    // Output decode for the sequencer.
    always_comb
    begin
        in_ready = 1'b0;
        do_load  = 1'b0;
        do_skip  = 1'b0;
        case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_SCAN:  do_skip  = !pend_reg[0];
            ST_FETCH: do_load  = slot_free;
            default:  ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (upd_accept && (|dirty_reg))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pend_reg[0])
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (do_load)
                begin
                    state_next = more_dirty ? ST_SCAN : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        on_val  = 13'd0;
        off_val = 13'(rd_data_reg >> 4);
        if (rd_data_reg == DUTY_FULL_ON)
        begin
            on_val  = full_on_code_reg;
            off_val = 13'd0;
        end
        else if (rd_data_reg == DUTY_FULL_OFF)
        begin
            off_val = full_on_code_reg;
        end
    end

    always_comb
    begin
        dirty_next     = dirty_reg;
        pend_next      = pend_reg;
        cnt_next       = cnt_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        if (set_accept && set_in_range)
        begin
            dirty_next = dirty_reg | (CHANNELS'(1) << in_data.channel[CW-1:0]);
        end
        if (upd_accept)
        begin
            dirty_next = '0;
            pend_next  = dirty_reg;
            cnt_next   = '0;
            prev_next  = 1'b0;
        end
        if (do_skip || do_load)
        begin
            pend_next = pend_shifted;
            cnt_next  = cnt_reg + CW'(1);
            prev_next = do_load;
        end
        if (do_load)
        begin
            out_valid_next       = 1'b1;
            out_next.bus_address = address_base_reg + {5'd0, device_index_reg, 1'b0};
            out_next.reg_address = REG_ADDR_BASE + (7'(cnt_reg) << 2);
            out_next.on_count    = on_val;
            out_next.off_count   = off_val;
            out_next.run_first   = !prev_reg;
            out_next.run_last    = !pend_shifted[0];
            out_next.last        = !more_dirty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dirty_reg     <= '0;
            pend_reg      <= '0;
            cnt_reg       <= '0;
            prev_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dirty_reg     <= dirty_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_walk_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (pend_reg != '0))
        else $error("Channel walk running with no dirty channel left.");

    a_update_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_accept && (dirty_reg != '0)) |=> ((state_reg == ST_SCAN) && !in_ready))
        else $error("Update transaction did not start the channel walk.");

    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (do_load && !more_dirty) |=> (state_reg == ST_IDLE))
        else $error("Walk continued after the final result.");

    a_fetch_on_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> pend_reg[0])
        else $error("Value fetched for a clean channel.");
`endif

endmodule
